[hdl/bdq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants, codes and the broadcast command type for the deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;

  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int POS_W   = 6;                 // fixed width of the position field
  localparam int VAL_W   = 32;                // fixed width of data_in / data_out
  localparam int OP_W    = 3;
  localparam int STAT_W  = 2;
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  // read-select tree: groups of cells reduced and registered first
  localparam int GROUP   = 8;
  localparam int NGRP    = (DEPTH + GROUP - 1) / GROUP;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  localparam logic [OP_W-1:0] OP_ADD_BACK   = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD_FRONT  = 3'd1;
  localparam logic [OP_W-1:0] OP_DROP_BACK  = 3'd2;
  localparam logic [OP_W-1:0] OP_DROP_FRONT = 3'd3;
  localparam logic [OP_W-1:0] OP_ERASE_AT   = 3'd4;
  localparam logic [OP_W-1:0] OP_READ_AT    = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  // command broadcast to every cell in the cycle a request is taken
  typedef struct packed {
    logic                  cap;         // request taken this cycle
    logic                  wr_back;     // write data at cell tail
    logic                  shift_up;    // push front: cell 0 takes data, every other cell its left neighbor
    logic                  shift_down;  // cells at pos and above take their right neighbor
    logic                  rd;          // cell pos drives the read tree
    logic [IDX_W-1:0]      pos;
    logic [IDX_W-1:0]      tail;
    logic [DATA_WIDTH-1:0] data;
  } bdq_cmd_t;

endpackage

[hdl/bdq_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_cell
// One storage cell of the deque; loads new data, or a neighbor's value when
// the row shifts, and drives its value onto the read tree when selected.
// ----------------------------------------------------------------------------
module bdq_cell import bdq_pkg::*; (
  input  logic                  clk,
  input  bdq_cmd_t              cmd,
  input  logic [IDX_W-1:0]      idx,       // this cell's place in the row
  input  logic [DATA_WIDTH-1:0] prev_val,  // neighbor toward the front
  input  logic [DATA_WIDTH-1:0] next_val,  // neighbor toward the back
  output logic [DATA_WIDTH-1:0] val,
  output logic [DATA_WIDTH-1:0] rd_val
);

  always_ff @(posedge clk) begin
    if (cmd.wr_back && (idx == cmd.tail)) begin
      val <= cmd.data;
    end else if (cmd.shift_up) begin
      val <= (idx == '0) ? cmd.data : prev_val;
    end else if (cmd.shift_down && (idx >= cmd.pos)) begin
      val <= next_val;
    end
  end

  assign rd_val = (cmd.rd && (idx == cmd.pos)) ? val : '0;

endmodule

[hdl/bdq_cell_row.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_cell_row
// Row of deque cells chained front to back, plus the read-select tree:
// per-group OR registered at request time, final OR the cycle after.
// ----------------------------------------------------------------------------
module bdq_cell_row import bdq_pkg::*; (
  input  logic                  clk,
  input  bdq_cmd_t              cmd,
  output logic [DATA_WIDTH-1:0] rd_data
);

  logic [DATA_WIDTH-1:0] vals    [DEPTH];
  logic [DATA_WIDTH-1:0] rd_vals [DEPTH];
  logic [DATA_WIDTH-1:0] grp     [NGRP];
  logic [DATA_WIDTH-1:0] grp_next[NGRP];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_v;
    logic [DATA_WIDTH-1:0] next_v;

    if (i == 0) begin : g_first
      assign prev_v = cmd.data;
    end else begin : g_mid_prev
      assign prev_v = vals[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_v = vals[i];
    end else begin : g_mid_next
      assign next_v = vals[i+1];
    end

    bdq_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .idx      (IDX_W'(i)),
      .prev_val (prev_v),
      .next_val (next_v),
      .val      (vals[i]),
      .rd_val   (rd_vals[i])
    );
  end

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < DEPTH) begin
          grp_next[g] = grp_next[g] | rd_vals[g * GROUP + k];
        end
      end
    end
  end

  // the group stage is sampled before the cells change, so a read sees the
  // contents as they stood when the request was taken
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      for (int g = 0; g < NGRP; g++) begin
        grp[g] <= grp_next[g];
      end
    end
  end

  always_comb begin
    rd_data = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_data = rd_data | grp[g];
    end
  end

endmodule

[hdl/bounded_deque_with_erase_unit.sv]
`timescale 1ns / 1ps
// A request transfer is followed by a result stage that moves its result to
// the output register; s_tready stays low until that move is made.
// A result held on m_tready lets one more request transfer in; the one after
//   waits until the held result is taken.
// Reset (rst, synchronous, active high) empties the deque; cell contents
//   are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
// bounded_deque_with_erase_unit
// Bounded deque with push/pop at both ends, erase and read by position, and
// clear, built as a row of shifting cells with a small request sequencer.
// ----------------------------------------------------------------------------
module bounded_deque_with_erase_unit import bdq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [2:0] opcode, [34:3] data_in, [40:35] position, [47:41] zero
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [31:0] data_out, [33:32] status, [40:34] element_count, [41] is_empty,
  // [47:42] zero
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DONE = 1'b1;

  logic              state;
  logic              state_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [STAT_W-1:0] res_status;
  logic [STAT_W-1:0] status_next;

  logic              out_valid;
  logic [VAL_W-1:0]  out_data;
  logic [STAT_W-1:0] out_status;
  logic [CNT_W-1:0]  out_count;
  logic              out_empty;

  logic [OP_W-1:0]   op;
  logic [VAL_W-1:0]  din;
  logic [POS_W-1:0]  pos;
  logic              acc;
  logic              full;
  logic              empty;
  logic              in_range;
  logic              load_out;

  bdq_cmd_t              cmd;
  logic [DATA_WIDTH-1:0] rd_data;

  assign op  = s_tdata[2:0];
  assign din = s_tdata[34:3];
  assign pos = s_tdata[40:35];

  assign s_tready = (state == S_IDLE);
  assign acc      = s_tvalid && s_tready;
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign in_range = (CMP_W'(pos) < CMP_W'(count));

  always_comb begin
    cmd            = '0;
    cmd.cap        = acc;
    cmd.pos        = IDX_W'(pos);
    cmd.tail       = IDX_W'(count);
    cmd.data       = DATA_WIDTH'(din);
    count_next     = count;
    status_next    = ST_OK;
    case (op)
      OP_ADD_BACK: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          cmd.wr_back = acc;
          count_next  = count + 1'b1;
        end
      end
      OP_ADD_FRONT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          cmd.shift_up = acc;
          count_next   = count + 1'b1;
        end
      end
      OP_DROP_BACK: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          count_next = count - 1'b1;
        end
      end
      OP_DROP_FRONT: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          cmd.shift_down = acc;
          cmd.pos        = '0;
          count_next     = count - 1'b1;
        end
      end
      OP_ERASE_AT: begin
        if (!in_range) begin
          status_next = ST_RANGE;
        end else begin
          cmd.shift_down = acc;
          count_next     = count - 1'b1;
        end
      end
      OP_READ_AT: begin
        if (!in_range) begin
          status_next = ST_RANGE;
        end else begin
          cmd.rd = acc;
        end
      end
      OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  bdq_cell_row u_row (
    .clk     (clk),
    .cmd     (cmd),
    .rd_data (rd_data)
  );

  // result moves to the output register once it is free
  assign load_out = (state == S_DONE) && (!out_valid || m_tready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (acc) begin
        count <= count_next;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_status <= status_next;
    end
    if (load_out) begin
      out_data   <= VAL_W'(rd_data);
      out_status <= res_status;
      out_count  <= count;
      out_empty  <= (count == '0);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_empty, 7'(out_count), out_status, out_data};

  // assertions
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("element count above depth");

  a_take_to_done: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_DONE))
    else $error("request transfer did not start result stage");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_empty == (out_count == '0)))
    else $error("empty flag disagrees with count");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status == ST_FULL)) |-> (out_count == CNT_W'(DEPTH)))
    else $error("full refusal with room left");

  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status != ST_OK)) |-> (out_data == '0))
    else $error("data on a failed request");

endmodule

[verif/deque_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_result_checker
// Watches the request and reply streams of the bounded deque, keeps its own
// copy of the element list, predicts each reply and compares it field by
// field in order of arrival.
// ----------------------------------------------------------------------------
module deque_result_checker import bdq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  output int                     mismatches,
  output int                     pending,
  output int                     requests_seen,
  output int                     replies_seen,
  output int                     full_refusals,
  output int                     empty_pops,
  output int                     range_misses,
  output int                     peak_fill
);

  typedef struct packed {
    logic [6:0]       pad;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] value;
    logic [OP_W-1:0]  op;
  } deque_request_t;

  typedef struct packed {
    logic [5:0]        pad;
    logic              empty;
    logic [CNT_W-1:0]  count;
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  data_out;
  } deque_reply_t;

  logic [DATA_WIDTH-1:0] cells [DEPTH];
  int                    held;
  deque_reply_t          predicted_replies [$];

  initial begin
    mismatches    = 0;
    pending       = 0;
    requests_seen = 0;
    replies_seen  = 0;
    full_refusals = 0;
    empty_pops    = 0;
    range_misses  = 0;
    peak_fill     = 0;
    held          = 0;
  end

  // Updates the element list for one request and returns the reply it causes.
  function automatic deque_reply_t apply_deque_request(input deque_request_t req);
    deque_reply_t r;
    int           i;
    r = '0;
    r.status = ST_OK;
    case (req.op)
      OP_ADD_BACK: begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          cells[held] = req.value[DATA_WIDTH-1:0];
          held++;
        end
      end
      OP_ADD_FRONT: begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = held; i > 0; i--) cells[i] = cells[i-1];
          cells[0] = req.value[DATA_WIDTH-1:0];
          held++;
        end
      end
      OP_DROP_BACK: begin
        if (held == 0) r.status = ST_EMPTY;
        else held--;
      end
      OP_DROP_FRONT: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (i = 0; i + 1 < held; i++) cells[i] = cells[i+1];
          held--;
        end
      end
      OP_ERASE_AT: begin
        if (int'(req.pos) >= held) begin
          r.status = ST_RANGE;
        end else begin
          for (i = int'(req.pos); i + 1 < held; i++) cells[i] = cells[i+1];
          held--;
        end
      end
      OP_READ_AT: begin
        if (int'(req.pos) >= held) r.status = ST_RANGE;
        else r.data_out = VAL_W'(cells[req.pos]);
      end
      OP_CLEAR: held = 0;
      default: ;  // spare opcode: no effect
    endcase
    r.count = CNT_W'(held);
    r.empty = (held == 0);
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [47:0] got,
                                 input logic [47:0] want);
    mismatches++;
    $display("[%0t] MISMATCH reply %0d %s: got %h want %h",
             $time, replies_seen, field, got, want);
  endtask

  always @(posedge clk) begin : monitor
    deque_reply_t want;
    deque_reply_t got;
    if (rst) begin
      held = 0;
      predicted_replies.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        want = apply_deque_request(deque_request_t'(s_tdata));
        predicted_replies = {predicted_replies, want};
        requests_seen++;
        if (want.status == ST_FULL)  full_refusals++;
        if (want.status == ST_EMPTY) empty_pops++;
        if (want.status == ST_RANGE) range_misses++;
        if (held > peak_fill) peak_fill = held;
      end
      if (m_tvalid && m_tready) begin
        got = deque_reply_t'(m_tdata);
        replies_seen++;
        if (predicted_replies.size() == 0) begin
          report_mismatch("unexpected transfer", m_tdata, 48'd0);
        end else begin
          want = predicted_replies[0];
          predicted_replies.delete(0);
          if (got.data_out !== want.data_out)
            report_mismatch("data_out", 48'(got.data_out), 48'(want.data_out));
          if (got.status !== want.status)
            report_mismatch("status", 48'(got.status), 48'(want.status));
          if (got.count !== want.count)
            report_mismatch("element_count", 48'(got.count), 48'(want.count));
          if (got.empty !== want.empty)
            report_mismatch("is_empty", 48'(got.empty), 48'(want.empty));
          if (got.pad !== want.pad)
            report_mismatch("pad bits", 48'(got.pad), 48'(want.pad));
        end
      end
    end
    pending = predicted_replies.size();
  end

endmodule

[verif/bounded_deque_with_erase_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_erase_unit_tb
// Drives request streams into the deque (directed corner cases, then random
// fill/drain tides under several idle and stall mixes plus one long output
// hold-off) and reports the verdict from the attached checker.
// ----------------------------------------------------------------------------
module bounded_deque_with_erase_unit_tb;
  import bdq_pkg::*;

  localparam int              RESET_CYCLES = 12;
  localparam int              HOLD_CYCLES  = 300;
  localparam int              QUIET_LIMIT  = 2000;
  localparam int              DRAIN_CYCLES = 10;
  localparam int              BLOCKS       = 8;
  localparam int              BLOCK_ITEMS  = 170;
  localparam int              SQUEEZE_ITEMS = 60;
  localparam logic [OP_W-1:0] OP_SPARE     = 3'd7;

  typedef enum {TIDE_FILL, TIDE_DRAIN, TIDE_MIXED} tide_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  logic hold_request = 1'b0;
  int   quiet_cycles = 0;

  int mismatches, pending, requests_seen, replies_seen;
  int full_refusals, empty_pops, range_misses, peak_fill;

  bounded_deque_with_erase_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  deque_result_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .mismatches    (mismatches),
    .pending       (pending),
    .requests_seen (requests_seen),
    .replies_seen  (replies_seen),
    .full_refusals (full_refusals),
    .empty_pops    (empty_pops),
    .range_misses  (range_misses),
    .peak_fill     (peak_fill)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // One request transfer, with random idle cycles ahead of it.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value,
                              input logic [POS_W-1:0] pos);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, pos, value, op};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic pick_request(input tide_t tide, output logic [OP_W-1:0] op,
                              output logic [VAL_W-1:0] value,
                              output logic [POS_W-1:0] pos);
    int r;
    r = $urandom_range(99);
    case (tide)
      TIDE_FILL: begin
        if (r < 40)      op = OP_ADD_BACK;
        else if (r < 80) op = OP_ADD_FRONT;
        else if (r < 85) op = OP_DROP_BACK;
        else if (r < 90) op = OP_DROP_FRONT;
        else if (r < 94) op = OP_ERASE_AT;
        else if (r < 99) op = OP_READ_AT;
        else             op = OP_SPARE;
      end
      TIDE_DRAIN: begin
        if (r < 5)       op = OP_ADD_BACK;
        else if (r < 10) op = OP_ADD_FRONT;
        else if (r < 30) op = OP_DROP_BACK;
        else if (r < 50) op = OP_DROP_FRONT;
        else if (r < 75) op = OP_ERASE_AT;
        else if (r < 95) op = OP_READ_AT;
        else if (r < 97) op = OP_CLEAR;
        else             op = OP_SPARE;
      end
      default: begin
        if (r < 20)      op = OP_ADD_BACK;
        else if (r < 40) op = OP_ADD_FRONT;
        else if (r < 50) op = OP_DROP_BACK;
        else if (r < 60) op = OP_DROP_FRONT;
        else if (r < 72) op = OP_ERASE_AT;
        else if (r < 92) op = OP_READ_AT;
        else if (r < 96) op = OP_CLEAR;
        else             op = OP_SPARE;
      end
    endcase
    case ($urandom_range(9))
      0:       value = 32'h8000_0000;
      1:       value = 32'h7fff_ffff;
      2:       value = 32'hffff_ffff;
      3:       value = 32'h0000_0000;
      default: value = $urandom();
    endcase
    // bias toward the front, where positions are in range even when nearly empty
    if ($urandom_range(99) < 40) pos = POS_W'($urandom_range(3));
    else                         pos = POS_W'($urandom_range(63));
  endtask

  // Output side: random stalls, or one long counted hold-off on request.
  initial begin : reply_side
    bit hold_taken;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("[%0t] watchdog: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int               blk;
    int               n;
    tide_t            tide;
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] pos;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // empty list: every removal and lookup is refused, clear still succeeds
    send_request(OP_DROP_BACK,  $urandom(), 6'd0);
    send_request(OP_DROP_FRONT, $urandom(), 6'd0);
    send_request(OP_ERASE_AT,   $urandom(), 6'd0);
    send_request(OP_READ_AT,    $urandom(), 6'd0);
    send_request(OP_CLEAR,      $urandom(), 6'd0);
    send_request(OP_SPARE,      $urandom(), 6'd63);
    // list becomes 0, -1, max, min
    send_request(OP_ADD_BACK,   32'h7fff_ffff, 6'd0);
    send_request(OP_ADD_BACK,   32'h8000_0000, 6'd63);
    send_request(OP_ADD_FRONT,  32'hffff_ffff, 6'd0);
    send_request(OP_ADD_FRONT,  32'h0000_0000, 6'd0);
    send_request(OP_READ_AT,    $urandom(), 6'd0);
    send_request(OP_READ_AT,    $urandom(), 6'd1);
    send_request(OP_READ_AT,    $urandom(), 6'd2);
    send_request(OP_READ_AT,    $urandom(), 6'd3);
    send_request(OP_READ_AT,    $urandom(), 6'd4);
    send_request(OP_READ_AT,    $urandom(), 6'd63);
    // erase in the middle, then the last element, then one past the end
    send_request(OP_ERASE_AT,   $urandom(), 6'd1);
    send_request(OP_ERASE_AT,   $urandom(), 6'd2);
    send_request(OP_ERASE_AT,   $urandom(), 6'd2);
    send_request(OP_DROP_BACK,  $urandom(), 6'd0);
    send_request(OP_DROP_FRONT, $urandom(), 6'd0);
    send_request(OP_ADD_BACK,   $urandom(), 6'd0);
    send_request(OP_CLEAR,      $urandom(), 6'd0);

    for (blk = 0; blk < BLOCKS; blk++) begin
      case (blk % 4)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 81; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 81; end
        default: begin tx_idle_pct = 36; rx_stall_pct = 36; end
      endcase
      // long fill stretch runs into the full bound, then drain, then mixed traffic
      for (n = 0; n < BLOCK_ITEMS; n++) begin
        if (n < 100)      tide = TIDE_FILL;
        else if (n < 150) tide = TIDE_DRAIN;
        else              tide = TIDE_MIXED;
        pick_request(tide, op, value, pos);
        send_request(op, value, pos);
      end
      if (blk == 0) begin
        // output held off while requests keep coming: the unit must back up
        hold_request <= 1'b1;
        for (n = 0; n < SQUEEZE_ITEMS; n++) begin
          pick_request(TIDE_MIXED, op, value, pos);
          send_request(op, value, pos);
        end
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests and %0d replies, peak fill %0d of %0d",
             requests_seen, replies_seen, peak_fill, DEPTH);
    $display("Refused: %0d pushes when full, %0d pops when empty, %0d out-of-range lookups",
             full_refusals, empty_pops, range_misses);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
